@@ hdl/hmr_pkg.sv @@
// ----------------------------------------------------------------------------
// hmr_pkg: shared constants and types of the histogram max rectangle unit
// Field widths, default bar capacity and the stack control word.
// ----------------------------------------------------------------------------
package hmr_pkg;

    localparam int MAX_BARS_DEF = 1024;
    localparam int HEIGHT_W     = 16;
    localparam int AREA_W       = 26;

    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    // command word from the sequencer to the index stack
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stk_ctl;

endpackage

@@ hdl/hmr_stack.sv @@
// ----------------------------------------------------------------------------
// hmr_stack: monotonic index stack
// Top entry in registers, lower entries in a memory with a registered read.
// After a pop the next entry is read into a read register, then loaded into the top.
// ----------------------------------------------------------------------------
module hmr_stack
    import hmr_pkg::*;
#(
    parameter int MAX_BARS = MAX_BARS_DEF,
    parameter int IW       = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1,
    parameter int CW       = $clog2(MAX_BARS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_stk_ctl            i_ctl,
    input  logic [IW-1:0]       i_idx,
    input  logic [HEIGHT_W-1:0] i_h,
    output logic                o_empty,
    output logic [IW-1:0]       o_top_idx,
    output logic [HEIGHT_W-1:0] o_top_h
);

    logic [CW-1:0]       r_depth;
    logic                r_pend;
    logic [IW-1:0]       r_top_idx;
    logic [HEIGHT_W-1:0] r_top_h;
    logic [IW-1:0]       r_rd_idx;
    logic [HEIGHT_W-1:0] r_rd_h;
    logic [IW-1:0]       m_idx [MAX_BARS];
    logic [HEIGHT_W-1:0] m_h   [MAX_BARS];
    logic [CW-1:0]       w_dm1;
    logic [CW-1:0]       w_dm2;

    assign w_dm1 = r_depth - CW'(1);
    assign w_dm2 = r_depth - CW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_depth <= '0;
            end else if (i_ctl.push) begin
                r_depth <= r_depth + CW'(1);
            end else if (i_ctl.pop) begin
                r_depth <= w_dm1;
            end
            r_pend <= i_ctl.pop && !i_ctl.clear;
        end
    end

    // top register: load on push, take the fetched entry after a pop
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_top_idx <= i_idx;
            r_top_h   <= i_h;
        end else if (r_pend) begin
            r_top_idx <= r_rd_idx;
            r_top_h   <= r_rd_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && r_depth != '0) begin
            m_idx[w_dm1[IW-1:0]] <= r_top_idx;
            m_h[w_dm1[IW-1:0]]   <= r_top_h;
        end
        if (i_ctl.pop && r_depth >= CW'(2)) begin
            r_rd_idx <= m_idx[w_dm2[IW-1:0]];
            r_rd_h   <= m_h[w_dm2[IW-1:0]];
        end
    end

    assign o_empty   = (r_depth == '0);
    assign o_top_idx = r_top_idx;
    assign o_top_h   = r_top_h;

endmodule

@@ hdl/hmr_bar_store.sv @@
// ----------------------------------------------------------------------------
// hmr_bar_store: per-bar height and left bound memories
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hmr_bar_store
    import hmr_pkg::*;
#(
    parameter int MAX_BARS = MAX_BARS_DEF,
    parameter int IW       = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1,
    parameter int LW       = IW + 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IW-1:0]       i_waddr,
    input  logic [HEIGHT_W-1:0] i_wh,
    input  logic [LW-1:0]       i_wleft,
    input  logic                i_re,
    input  logic [IW-1:0]       i_raddr,
    output logic [HEIGHT_W-1:0] o_rh,
    output logic [LW-1:0]       o_rleft
);

    logic [HEIGHT_W-1:0] m_h    [MAX_BARS];
    logic [LW-1:0]       m_left [MAX_BARS];
    logic [HEIGHT_W-1:0] r_rh;
    logic [LW-1:0]       r_rleft;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            m_h[i_waddr]    <= i_wh;
            m_left[i_waddr] <= i_wleft;
        end
        if (i_re) begin
            r_rh    <= m_h[i_raddr];
            r_rleft <= m_left[i_raddr];
        end
    end

    assign o_rh    = r_rh;
    assign o_rleft = r_rleft;

endmodule

@@ hdl/histogram_max_rectangle_unit.sv @@
// ----------------------------------------------------------------------------
// histogram_max_rectangle_unit: largest rectangle under a streamed histogram
// Bars arrive one word at a time; the word flagged last_bar closes the
// histogram and yields one max_area word.
//
//   channel | direction | handshake               | payload
//   bar in  | input     | i_in_valid / o_in_ready | i_bar_height, i_last_bar
//   area out| output    | o_out_valid / i_out_ready | o_max_area
//
// Load: each bar is checked against the stack top, and each stack pop
// adds a wait state for the stack memory read. After the last bar a
// right-to-left pass reads, checks, multiplies and compares each bar, with
// a wait state per pop, between a setup and a finish step. Pops amortize to one per bar.
// Reset is synchronous, active low, and empties the histogram; no
// clearing pass is needed. o_in_ready is low while a bar or the pass is
// in work; a waiting result holds only the finish step.
// ----------------------------------------------------------------------------
module histogram_max_rectangle_unit
    import hmr_pkg::*;
#(
    parameter int MAX_BARS = MAX_BARS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [HEIGHT_W-1:0] i_bar_height,
    input  logic                i_last_bar,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [AREA_W-1:0]   o_max_area
);

    localparam int IW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam int CW = $clog2(MAX_BARS + 1);
    localparam int LW = IW + 1;
    localparam int PW = CW + HEIGHT_W;
    localparam int MW = (PW > AREA_W) ? PW : AREA_W;
    localparam int XW = CW + 2;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CHK    = 10'b0000000010,
        S_LWAIT  = 10'b0000000100,
        S_RINIT  = 10'b0000001000,
        S_RRD    = 10'b0000010000,
        S_RCHK   = 10'b0000100000,
        S_RPWAIT = 10'b0001000000,
        S_RMUL   = 10'b0010000000,
        S_RCMP   = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_count;
    logic                r_out_valid;
    logic [HEIGHT_W-1:0] r_hin;
    logic                r_last;
    logic [IW-1:0]       r_k;
    logic [CW-1:0]       r_width;
    logic [HEIGHT_W-1:0] r_hc;
    logic [PW-1:0]       r_area;
    logic [PW-1:0]       r_best;
    logic [AREA_W-1:0]   r_max_area;

    t_stk_ctl            w_ctl;
    logic [IW-1:0]       w_push_idx;
    logic [HEIGHT_W-1:0] w_push_h;
    logic                w_empty;
    logic [IW-1:0]       w_top_idx;
    logic [HEIGHT_W-1:0] w_top_h;
    logic [HEIGHT_W-1:0] w_rd_h;
    logic [LW-1:0]       w_rd_left;
    logic [LW-1:0]       w_left_new;
    logic [HEIGHT_W-1:0] w_hcur;
    logic                w_ge;
    logic [XW-1:0]       w_right;
    logic [XW-1:0]       w_wid;
    logic [MW-1:0]       w_best_x;
    logic                w_accept;
    logic                w_fin_go;
    logic                w_has_room;
    logic                w_store_we;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_fin_go   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign w_has_room = (r_count < CW'(MAX_BARS));

    // shared height compare: pop while the top is not strictly lower
    assign w_hcur = (r_state == S_CHK) ? r_hin : w_rd_h;
    assign w_ge   = !w_empty && (w_top_h >= w_hcur);

    assign w_left_new = w_empty ? {LW{1'b1}} : LW'(w_top_idx);
    assign w_right    = w_empty ? XW'(r_count) : XW'(w_top_idx);
    assign w_wid      = w_right - {{(XW-LW){w_rd_left[LW-1]}}, w_rd_left} - XW'(1);

    assign w_store_we = (r_state == S_CHK) && !w_ge;

    always_comb begin
        w_ctl       = '0;
        w_push_idx  = r_k;
        w_push_h    = w_rd_h;
        unique case (r_state)
            S_CHK: begin
                w_ctl.pop  = w_ge;
                w_ctl.push = !w_ge;
                w_push_idx = r_count[IW-1:0];
                w_push_h   = r_hin;
            end
            S_RCHK: begin
                w_ctl.pop  = w_ge;
                w_ctl.push = !w_ge;
            end
            S_RINIT: w_ctl.clear = 1'b1;
            S_FIN:   w_ctl.clear = w_fin_go;
            default: w_ctl = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_has_room) begin
                        n_state = S_CHK;
                    end else if (i_last_bar) begin
                        n_state = S_RINIT;
                    end
                end
            end
            S_CHK: begin
                if (w_ge) begin
                    n_state = S_LWAIT;
                end else if (r_last) begin
                    n_state = S_RINIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LWAIT:  n_state = S_CHK;
            S_RINIT:  n_state = S_RRD;
            S_RRD:    n_state = S_RCHK;
            S_RCHK:   n_state = w_ge ? S_RPWAIT : S_RMUL;
            S_RPWAIT: n_state = S_RCHK;
            S_RMUL:   n_state = S_RCMP;
            S_RCMP:   n_state = (r_k == '0) ? S_FIN : S_RRD;
            S_FIN:    n_state = w_fin_go ? S_IDLE : S_FIN;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin_go) begin
                r_count <= '0;
            end else if (w_store_we) begin
                r_count <= r_count + CW'(1);
            end
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // widen the running maximum so it can be saturated to the output field
    assign w_best_x = MW'(r_best);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hin  <= i_bar_height;
            r_last <= i_last_bar;
        end
        if (r_state == S_RINIT) begin
            r_k    <= IW'(r_count - CW'(1));
            r_best <= '0;
        end
        if (r_state == S_RCHK) begin
            r_width <= w_wid[CW-1:0];
            r_hc    <= w_rd_h;
        end
        if (r_state == S_RMUL) begin
            r_area <= PW'(r_width) * PW'(r_hc);
        end
        if (r_state == S_RCMP) begin
            if (r_area > r_best) begin
                r_best <= r_area;
            end
            r_k <= r_k - IW'(1);
        end
        if (w_fin_go) begin
            r_max_area <= (w_best_x > MW'(AREA_MAX)) ? AREA_MAX : w_best_x[AREA_W-1:0];
        end
    end

    hmr_stack #(
        .MAX_BARS (MAX_BARS),
        .IW       (IW),
        .CW       (CW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_idx     (w_push_idx),
        .i_h       (w_push_h),
        .o_empty   (w_empty),
        .o_top_idx (w_top_idx),
        .o_top_h   (w_top_h)
    );

    hmr_bar_store #(
        .MAX_BARS (MAX_BARS),
        .IW       (IW),
        .LW       (LW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wh    (r_hin),
        .i_wleft (w_left_new),
        .i_re    (r_state == S_RRD),
        .i_raddr (r_k),
        .o_rh    (w_rd_h),
        .o_rleft (w_rd_left)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_max_area  = r_max_area;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for histogram_max_rectangle_unit
// Streams histograms of many shapes and lengths into the unit, one over the
// bar capacity among them. A scoreboard rebuilds the largest rectangle of
// each closed histogram and checks every max_area word in order. Both
// channels idle in random bursts, and the receiver holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import hmr_pkg::*;

    localparam int BARS       = MAX_BARS_DEF;
    localparam int RAND_BARS  = 1200;
    localparam int CALM_AFTER = 1000;
    localparam int HOLD_LEN   = 400;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_FEW_LEVELS,
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_EXTREMES,
        SHAPE_TALL,
        SHAPE_FLAT_MAX
    } t_shape;

    // Rebuilds the largest rectangle of each histogram and holds the areas
    // still owed by the unit.
    class t_max_rect_scoreboard;
        logic [HEIGHT_W-1:0] bar_h [BARS];
        int                  left_lim [BARS];
        int                  stk [BARS];
        int                  depth = 0;
        int                  n_loaded = 0;
        logic [AREA_W-1:0]   pending_areas [$];
        int                  n_errors = 0;
        int                  n_checked = 0;

        function automatic logic [AREA_W-1:0] sweep_right();
            int     k;
            int     right;
            longint area;
            longint best;
            depth = 0;
            best  = 0;
            for (k = n_loaded - 1; k >= 0; k--) begin
                while (depth > 0 && bar_h[stk[depth-1]] >= bar_h[k])
                    depth--;
                right = (depth == 0) ? n_loaded : stk[depth-1];
                area  = longint'(right - left_lim[k] - 1) * longint'(bar_h[k]);
                if (area > best)
                    best = area;
                stk[depth] = k;
                depth++;
            end
            if (best > longint'(AREA_MAX))
                return AREA_MAX;
            return best[AREA_W-1:0];
        endfunction

        function automatic void add_bar(logic [HEIGHT_W-1:0] h, logic last);
            logic [AREA_W-1:0] closed_area;
            // drop bars past capacity, but still honor the last mark
            if (n_loaded < BARS) begin
                while (depth > 0 && bar_h[stk[depth-1]] >= h)
                    depth--;
                left_lim[n_loaded] = (depth == 0) ? -1 : stk[depth-1];
                bar_h[n_loaded]    = h;
                stk[depth]         = n_loaded;
                depth++;
                n_loaded++;
            end
            if (last) begin
                closed_area   = sweep_right();
                pending_areas = {pending_areas, closed_area};
                depth    = 0;
                n_loaded = 0;
            end
        endfunction

        function automatic void check_area(logic [AREA_W-1:0] got);
            logic [AREA_W-1:0] want;
            n_checked++;
            if (pending_areas.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: max_area %0d with no histogram closed", got);
            end else begin
                want = pending_areas.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: max_area expected %0d, got %0d", want, got);
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [HEIGHT_W-1:0] i_bar_height;
    logic                i_last_bar;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [AREA_W-1:0]   o_max_area;

    t_max_rect_scoreboard sb;
    logic calm;
    logic hold_off;
    int   n_bars_sent;
    int   n_hists;
    int   n_results;
    int   n_errs_total;

    histogram_max_rectangle_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_bar_height (i_bar_height),
        .i_last_bar   (i_last_bar),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_max_area   (o_max_area)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("tb_top failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.add_bar(i_bar_height, i_last_bar);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_area(o_max_area);
            n_results++;
        end
    end

    // receiver: random stall bursts, none once the run turns calm
    initial begin : receiver
        int gap_left;
        gap_left    = 0;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (gap_left == 0 && !calm && $urandom_range(0, 7) == 0)
                gap_left = $urandom_range(1, 10);
            if (hold_off || gap_left > 0)
                i_out_ready <= 1'b0;
            else
                i_out_ready <= 1'b1;
            if (gap_left > 0)
                gap_left--;
        end
    end

    // hold the result side off long enough for the unit to back up
    initial begin
        hold_off = 1'b0;
        wait (n_results >= 12);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_off = 1'b0;
    end

    task automatic send_bar(input logic [HEIGHT_W-1:0] h, input logic last);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_bar_height <= h;
        i_last_bar   <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        n_bars_sent++;
        if (last)
            n_hists++;
    endtask

    task automatic send_histogram(input int len, input t_shape shape);
        int                  k;
        int                  base;
        int                  step;
        logic [HEIGHT_W-1:0] h;
        base = $urandom_range(0, 1000);
        step = $urandom_range(0, 60);
        for (k = 0; k < len; k++) begin
            case (shape)
                SHAPE_FEW_LEVELS: h = HEIGHT_W'($urandom_range(0, 3));
                SHAPE_RISING:     h = HEIGHT_W'(base + k * step);
                SHAPE_FALLING:    h = HEIGHT_W'(65535 - base - k * step);
                SHAPE_EXTREMES: begin
                    case ($urandom_range(0, 2))
                        0:       h = '0;
                        1:       h = '1;
                        default: h = HEIGHT_W'($urandom);
                    endcase
                end
                SHAPE_TALL:       h = HEIGHT_W'($urandom_range(60000, 65535));
                SHAPE_FLAT_MAX:   h = '1;
                default:          h = HEIGHT_W'($urandom);
            endcase
            send_bar(h, k == len - 1);
        end
    endtask

    initial begin : stimulus
        int     len;
        int     pick;
        int     rand_bars;
        logic   big_done;
        t_shape shape;

        sb           = new;
        calm         = 1'b0;
        n_bars_sent  = 0;
        n_hists      = 0;
        n_results    = 0;
        rand_bars    = 0;
        big_done     = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_bar_height = '0;
        i_last_bar   = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single bars at both height extremes
        send_bar(16'd0, 1'b1);
        send_bar(16'hFFFF, 1'b1);
        // equal tallest bars: ties must not split the rectangle
        send_bar(16'hFFFF, 1'b0);
        send_bar(16'hFFFF, 1'b0);
        send_bar(16'hFFFF, 1'b1);
        // textbook case, area 10
        send_bar(16'd2, 1'b0);
        send_bar(16'd1, 1'b0);
        send_bar(16'd5, 1'b0);
        send_bar(16'd6, 1'b0);
        send_bar(16'd2, 1'b0);
        send_bar(16'd3, 1'b1);
        // rising then falling runs
        send_bar(16'd1, 1'b0);
        send_bar(16'd2, 1'b0);
        send_bar(16'd3, 1'b0);
        send_bar(16'd4, 1'b1);
        send_bar(16'd4, 1'b0);
        send_bar(16'd3, 1'b0);
        send_bar(16'd2, 1'b0);
        send_bar(16'd1, 1'b1);
        // zero bars split a tall one
        send_bar(16'd0, 1'b0);
        send_bar(16'hFFFF, 1'b0);
        send_bar(16'd0, 1'b1);

        while (rand_bars < RAND_BARS) begin
            if (rand_bars >= CALM_AFTER)
                calm <= 1'b1;
            if (!big_done && rand_bars >= 40) begin
                // overfill: bars past capacity are dropped, last still closes
                send_histogram(BARS + 6, SHAPE_FLAT_MAX);
                big_done = 1'b1;
                rand_bars += BARS + 6;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7)
                len = $urandom_range(1, 8);
            else if (pick < 9)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(25, 80);
            shape = t_shape'($urandom_range(0, 5));
            send_histogram(len, shape);
            rand_bars += len;
        end

        i_in_valid <= 1'b0;
        while (sb.pending_areas.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        n_errs_total = sb.n_errors + sb.pending_areas.size();
        $display("covered %0d bars in %0d histograms, one of %0d bars past capacity",
                 n_bars_sent, n_hists, BARS + 6);
        $display("checked %0d max_area words, %0d mismatches", sb.n_checked, n_errs_total);
        if (n_errs_total == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
